// ----- sv/bib_pkg.sv -----
// ----------------------------------------------------------------------------
// bib_pkg
// Shared constants, types and command/status bundles of the bucket index
// builder.
// ----------------------------------------------------------------------------
package bib_pkg;

  localparam int RUN_DEPTH = 16;
  localparam int KeyW = 32;
  localparam int PosW = 32;
  localparam int CountW = 32;
  localparam int ThrW = 5;
  localparam int RunCountW = 6;
  localparam logic [RunCountW-1:0] RunCountMax = '1;
  localparam int BufAw = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(16);

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_FILL  = 1'b1;

  typedef enum logic [1:0] {
    EMIT_FILL,
    EMIT_ENTRY,
    EMIT_OFFSET
  } emit_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      write_entry;
    logic      clear_set;
    logic      idx_clr;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_eor;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic kept;
    logic fill_needed;
    logic second_emits;
    logic last_entry;
    logic slot_free;
    logic fin;
  } sts_t;

endpackage

// ----- sv/bib_ctrl.sv -----
// ----------------------------------------------------------------------------
// bib_ctrl
// Sequencer: takes one transaction, closes the open run if the key changed,
// writes the entry, closes the run again on the final entry.
// ----------------------------------------------------------------------------
module bib_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bib_pkg::sts_t sts,
  output bib_pkg::cmd_t cmd
);
  import bib_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CLOSE,
    S_FILL,
    S_ENTRY,
    S_OFFSET,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   phase_b, phase_b_next;

  always_comb begin
    state_next   = state;
    phase_b_next = phase_b;
    cmd          = '0;
    cmd.emit_sel = EMIT_FILL;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.changed) begin
          phase_b_next = 1'b0;
          state_next   = S_CLOSE;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_CLOSE: begin
        cmd.idx_clr = 1'b1;
        if (!sts.kept) begin
          state_next = phase_b ? S_FINISH : S_WRITE;
        end else if (sts.fill_needed) begin
          state_next = S_FILL;
        end else begin
          state_next = S_ENTRY;
        end
      end
      S_FILL: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_FILL;
          state_next   = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_ENTRY;
          if (sts.last_entry) begin
            state_next = S_OFFSET;
          end
        end
      end
      S_OFFSET: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_OFFSET;
          cmd.emit_eor = phase_b || !sts.second_emits;
          state_next   = phase_b ? S_FINISH : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        if (sts.fin) begin
          phase_b_next = 1'b1;
          state_next   = S_CLOSE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FINISH: begin
        cmd.clear_set = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase_b <= 1'b0;
    end else begin
      state   <= state_next;
      phase_b <= phase_b_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ----- sv/bib_datapath.sv -----
// ----------------------------------------------------------------------------
// bib_datapath
// Run state, run buffer, threshold register and the result register.
// ----------------------------------------------------------------------------
module bib_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  bib_pkg::cmd_t              cmd,
  output bib_pkg::sts_t              sts,
  input  logic [bib_pkg::KeyW-1:0]   key,
  input  logic [bib_pkg::PosW-1:0]   position,
  input  logic                       strand_bit,
  input  logic                       final_entry,
  input  logic                       cfg_we,
  input  logic [bib_pkg::ThrW-1:0]   cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       kind,
  output logic [bib_pkg::KeyW-1:0]   first_key,
  output logic [bib_pkg::KeyW-1:0]   last_key,
  output logic [bib_pkg::CountW-1:0] offset,
  output logic [bib_pkg::PosW-1:0]   out_position,
  output logic                       out_strand,
  output logic                       end_of_run
);
  import bib_pkg::*;

  function automatic logic run_kept(logic [RunCountW-1:0] cnt, logic [ThrW-1:0] thr);
    return (cnt != '0) && ((cnt - RunCountW'(1)) < RunCountW'(thr));
  endfunction

  logic [KeyW-1:0]      in_key;
  logic [PosW-1:0]      in_pos;
  logic                 in_strand;
  logic                 in_fin;
  logic [ThrW-1:0]      max_run_extra;
  logic [KeyW-1:0]      current_key;
  logic                 have_run;
  logic [RunCountW-1:0] run_count;
  logic [CountW-1:0]    entry_count;
  logic [KeyW:0]        next_fill_key;
  logic [RunCountW-1:0] idx;
  logic [PosW:0]        run_buffer [RUN_DEPTH];

  logic [ThrW-1:0]      thr;
  logic                 restart;
  logic [RunCountW-1:0] new_count;
  logic [RunCountW-1:0] wr_idx;
  logic                 slot_free;

  always_comb begin
    thr = (max_run_extra > ThrW'(RUN_DEPTH)) ? ThrW'(RUN_DEPTH) : max_run_extra;
    restart = !have_run || (in_key != current_key);
    if (restart) begin
      new_count = RunCountW'(1);
    end else if (run_count == RunCountMax) begin
      new_count = run_count;
    end else begin
      new_count = run_count + RunCountW'(1);
    end
    wr_idx    = restart ? '0 : run_count;
    slot_free = !out_valid || !out_stall;

    sts.changed      = have_run && (in_key != current_key);
    sts.kept         = run_kept(run_count, thr);
    sts.fill_needed  = next_fill_key < {1'b0, current_key};
    sts.second_emits = in_fin && run_kept(new_count, thr);
    sts.last_entry   = (idx + RunCountW'(1)) == run_count;
    sts.slot_free    = slot_free;
    sts.fin          = in_fin;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_key    <= key;
      in_pos    <= position;
      in_strand <= strand_bit;
      in_fin    <= final_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_entry && (wr_idx < RunCountW'(RUN_DEPTH))) begin
      run_buffer[wr_idx[BufAw-1:0]] <= {in_pos, in_strand};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run_extra <= ThrReset;
    end else if (cfg_we) begin
      max_run_extra <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_key   <= '0;
      have_run      <= 1'b0;
      run_count     <= '0;
      entry_count   <= '0;
      next_fill_key <= '0;
      idx           <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end
      if (cmd.write_entry) begin
        current_key <= in_key;
        have_run    <= 1'b1;
        run_count   <= new_count;
      end
      if (cmd.emit && (cmd.emit_sel == EMIT_ENTRY)) begin
        entry_count <= entry_count + CountW'(1);
        idx         <= idx + RunCountW'(1);
      end
      if (cmd.emit && (cmd.emit_sel == EMIT_OFFSET)) begin
        next_fill_key <= {1'b0, current_key} + (KeyW+1)'(1);
      end
      if (cmd.clear_set) begin
        have_run      <= 1'b0;
        run_count     <= '0;
        entry_count   <= '0;
        next_fill_key <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      end_of_run <= cmd.emit_eor;
      offset     <= entry_count;
      case (cmd.emit_sel)
        EMIT_FILL: begin
          kind         <= KIND_FILL;
          first_key    <= next_fill_key[KeyW-1:0];
          last_key     <= current_key - KeyW'(1);
          out_position <= '0;
          out_strand   <= 1'b0;
        end
        EMIT_ENTRY: begin
          kind         <= KIND_ENTRY;
          first_key    <= '0;
          last_key     <= '0;
          out_position <= run_buffer[idx[BufAw-1:0]][PosW:1];
          out_strand   <= run_buffer[idx[BufAw-1:0]][0];
        end
        EMIT_OFFSET: begin
          kind         <= KIND_FILL;
          first_key    <= current_key;
          last_key     <= current_key;
          out_position <= '0;
          out_strand   <= 1'b0;
        end
        default: begin
          kind         <= KIND_FILL;
          first_key    <= '0;
          last_key     <= '0;
          out_position <= '0;
          out_strand   <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- sv/bucket_index_builder_with_filter.sv -----
// ----------------------------------------------------------------------------
// bucket_index_builder_with_filter
// Builds a bucketed index from key-sorted entries, dropping oversized runs.
// Each transaction is taken only in idle; in_stall stays high until the
// block has handled it. A key change first closes the open run: a kept run
// emits an optional fill, one result per entry and an offset result, each
// waiting while the output is stalled; a dropped run emits nothing. A final
// entry also closes its own run after it is written.
// Synchronous reset clears control state; threshold returns to 16.
// ----------------------------------------------------------------------------
module bucket_index_builder_with_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bib_pkg::KeyW-1:0]   key,
  input  logic [bib_pkg::PosW-1:0]   position,
  input  logic                       strand_bit,
  input  logic                       final_entry,
  input  logic                       cfg_we,
  input  logic [bib_pkg::ThrW-1:0]   cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       kind,
  output logic [bib_pkg::KeyW-1:0]   first_key,
  output logic [bib_pkg::KeyW-1:0]   last_key,
  output logic [bib_pkg::CountW-1:0] offset,
  output logic [bib_pkg::PosW-1:0]   out_position,
  output logic                       out_strand,
  output logic                       end_of_run
);
  import bib_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bib_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bib_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .key          (key),
    .position     (position),
    .strand_bit   (strand_bit),
    .final_entry  (final_entry),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .first_key    (first_key),
    .last_key     (last_key),
    .offset       (offset),
    .out_position (out_position),
    .out_strand   (out_strand),
    .end_of_run   (end_of_run)
  );

endmodule
